// ----- design/spa_pkg.sv -----
// spa_pkg: shared types and constants for the sparse polynomial add/sub block
// transaction structs, item kind codes, store entry and merge control types
// no dependencies
`default_nettype none

package spa_pkg;

  localparam int MAX_TERMS_DEFAULT = 16;

  // item kind codes
  localparam logic [2:0] KIND_LOAD_FIRST  = 3'd0;
  localparam logic [2:0] KIND_LOAD_SECOND = 3'd1;
  localparam logic [2:0] KIND_ADD         = 3'd2;
  localparam logic [2:0] KIND_SUB         = 3'd3;
  localparam logic [2:0] KIND_CLEAR       = 3'd4;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] coefficient;
    logic [15:0]        exponent;
  } item_t;

  typedef struct packed {
    logic signed [32:0] result_coefficient;
    logic [15:0]        result_exponent;
    logic               zero_polynomial;
    logic               capacity_exceeded;
    logic               last;
  } result_t;

  // one stored term
  typedef struct packed {
    logic signed [31:0] coeff;
    logic [15:0]        expo;
  } entry_t;

  // start request from the front end to the merge engine
  typedef struct packed {
    logic start;
    logic subtract;
    logic overflow;
  } merge_ctl_t;

  typedef enum logic {
    MS_IDLE,
    MS_MERGE
  } merge_state_t;

endpackage

`default_nettype wire

// ----- design/sparse_polynomial_add_sub.sv -----
// sparse_polynomial_add_sub: top level of the sparse polynomial adder/subtractor
// front end with counts and overflow flag, two term stores and the merge engine
// depends on spa_pkg, spa_store, spa_merge
//
// channel   | valid        | stall         | payload
// ----------+--------------+---------------+-----------------------------------
// item      | item_valid   | item_stall    | item   (kind, coefficient, exponent)
// result    | result_valid | result_stall  | result (term, zero, capacity, last)
//
// load, clear and unused kinds do not stall the input and are taken back to back
// add/subtract holds item_stall for at most first_count + second_count merge
//   steps plus a final step, one merge step per cycle unless a result stall
//   holds it, set by the one read port on each store; a result stall pauses the merge only while result_valid is high
// reset clears counts, overflow flag and the merge engine; stores are not cleared
// a new transaction is taken while the last result still waits on the output
`default_nettype none

module sparse_polynomial_add_sub #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_stall,
  input  wire spa_pkg::item_t item,
  output logic                result_valid,
  input  wire logic           result_stall,
  output spa_pkg::result_t    result
);
  import spa_pkg::*;

  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // term counts and overflow flag
  logic [CW-1:0] first_count, first_count_next;
  logic [CW-1:0] second_count, second_count_next;
  logic          overflow, overflow_next;

  logic          accept;
  logic          busy;
  logic          wr_first, wr_second;
  entry_t        wr_entry;
  merge_ctl_t    ctl;

  logic [AW-1:0] rd_addr_first, rd_addr_second;
  entry_t        rd_first, rd_second;

  // input is held off while the merge walks the stores
  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;

  assign wr_entry = '{coeff: item.coefficient, expo: item.exponent};

  // decode one accepted transaction
  always_comb begin
    first_count_next  = first_count;
    second_count_next = second_count;
    overflow_next     = overflow;
    wr_first          = 1'b0;
    wr_second         = 1'b0;
    ctl               = '{start: 1'b0, subtract: 1'b0, overflow: overflow};
    if (accept) begin
      unique case (item.kind)
        KIND_LOAD_FIRST: begin
          // zero coefficient terms are ignored
          if (item.coefficient != 0) begin
            if (first_count < CW'(MAX_TERMS)) begin
              wr_first         = 1'b1;
              first_count_next = first_count + CW'(1);
            end else begin
              overflow_next = 1'b1;
            end
          end
        end
        KIND_LOAD_SECOND: begin
          if (item.coefficient != 0) begin
            if (second_count < CW'(MAX_TERMS)) begin
              wr_second         = 1'b1;
              second_count_next = second_count + CW'(1);
            end else begin
              overflow_next = 1'b1;
            end
          end
        end
        KIND_ADD, KIND_SUB: begin
          ctl.start    = 1'b1;
          ctl.subtract = (item.kind == KIND_SUB);
        end
        KIND_CLEAR: begin
          first_count_next  = '0;
          second_count_next = '0;
          overflow_next     = 1'b0;
        end
        default: ;  // unused kinds do nothing
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      overflow     <= 1'b0;
    end else begin
      first_count  <= first_count_next;
      second_count <= second_count_next;
      overflow     <= overflow_next;
    end
  end

  // first polynomial store
  spa_store #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_store_first (
    .clk     (clk),
    .wr_en   (wr_first),
    .wr_addr (first_count[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr_first),
    .rd_data (rd_first)
  );

  // second polynomial store
  spa_store #(
    .DEPTH (MAX_TERMS),
    .AW    (AW)
  ) u_store_second (
    .clk     (clk),
    .wr_en   (wr_second),
    .wr_addr (second_count[AW-1:0]),
    .wr_data (wr_entry),
    .rd_addr (rd_addr_second),
    .rd_data (rd_second)
  );

  // merge engine, owns the result register
  spa_merge #(
    .MAX_TERMS (MAX_TERMS),
    .CW        (CW),
    .AW        (AW)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .first_count    (first_count),
    .second_count   (second_count),
    .rd_addr_first  (rd_addr_first),
    .rd_addr_second (rd_addr_second),
    .rd_first       (rd_first),
    .rd_second      (rd_second),
    .busy           (busy),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .result         (result)
  );

endmodule

`default_nettype wire

// ----- design/spa_store.sv -----
// spa_store: term store of one polynomial, one write and one read port
// read data registered; uses spa_pkg
`default_nettype none

module spa_store #(
  parameter int DEPTH = spa_pkg::MAX_TERMS_DEFAULT,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            wr_en,
  input  wire logic [AW-1:0]   wr_addr,
  input  wire spa_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]   rd_addr,
  output spa_pkg::entry_t      rd_data
);
  import spa_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- design/spa_merge.sv -----
// spa_merge: two-pointer merge over both term stores, one step per cycle unless a held result stalls it
// holds back one term so the final one can be marked last; uses spa_pkg
`default_nettype none

module spa_merge #(
  parameter int MAX_TERMS = spa_pkg::MAX_TERMS_DEFAULT,
  parameter int CW = $clog2(MAX_TERMS + 1),
  parameter int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spa_pkg::merge_ctl_t ctl,
  input  wire logic [CW-1:0]       first_count,
  input  wire logic [CW-1:0]       second_count,
  output logic [AW-1:0]            rd_addr_first,
  output logic [AW-1:0]            rd_addr_second,
  input  wire spa_pkg::entry_t     rd_first,
  input  wire spa_pkg::entry_t     rd_second,
  output logic                     busy,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output spa_pkg::result_t         result
);
  import spa_pkg::*;

  merge_state_t state, state_next;

  logic [CW-1:0]      i, i_next;
  logic [CW-1:0]      j, j_next;
  logic               subtract;
  logic               overflow;
  logic               hold_valid, hold_valid_next;
  logic signed [32:0] hold_coef, hold_coef_next;
  logic [15:0]        hold_exp, hold_exp_next;

  logic               a_ok, b_ok, done, advance, out_free;
  logic signed [32:0] coef_a, coef_b, cand_coef;
  logic [15:0]        cand_exp;
  logic               inc_i, inc_j;
  logic               push;
  result_t            push_item;

  assign out_free = !result_valid || !result_stall;
  assign a_ok     = i < first_count;
  assign b_ok     = j < second_count;
  assign done     = !a_ok && !b_ok;
  assign advance  = (state == MS_MERGE) && out_free;
  assign busy     = (state != MS_IDLE);

  // candidate term at the current heads
  always_comb begin
    coef_a = {rd_first.coeff[31], rd_first.coeff};
    coef_b = {rd_second.coeff[31], rd_second.coeff};
    if (subtract) begin
      coef_b = -coef_b;
    end
    inc_i     = 1'b0;
    inc_j     = 1'b0;
    cand_coef = coef_b;
    cand_exp  = rd_second.expo;
    if (a_ok && b_ok && rd_first.expo == rd_second.expo) begin
      cand_coef = coef_a + coef_b;
      cand_exp  = rd_first.expo;
      inc_i     = 1'b1;
      inc_j     = 1'b1;
    end else if (!b_ok || (a_ok && rd_first.expo > rd_second.expo)) begin
      cand_coef = coef_a;
      cand_exp  = rd_first.expo;
      inc_i     = 1'b1;
    end else begin
      inc_j     = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      MS_IDLE: begin
        if (ctl.start) begin
          state_next = MS_MERGE;
        end
      end
      MS_MERGE: begin
        if (advance && done) begin
          state_next = MS_IDLE;
        end
      end
      default: state_next = MS_IDLE;
    endcase
  end

  // pointers, hold stage and output push
  always_comb begin
    i_next          = i;
    j_next          = j;
    hold_valid_next = hold_valid;
    hold_coef_next  = hold_coef;
    hold_exp_next   = hold_exp;
    push            = 1'b0;
    push_item       = '{result_coefficient: hold_coef, result_exponent: hold_exp,
                        zero_polynomial: 1'b0, capacity_exceeded: overflow,
                        last: 1'b0};
    unique case (state)
      MS_IDLE: begin
        i_next = '0;
        j_next = '0;
      end
      MS_MERGE: begin
        if (advance) begin
          if (done) begin
            push            = 1'b1;
            push_item.last  = 1'b1;
            hold_valid_next = 1'b0;
            if (!hold_valid) begin
              push_item.result_coefficient = '0;
              push_item.result_exponent    = '0;
              push_item.zero_polynomial    = 1'b1;
            end
          end else begin
            i_next = i + CW'(inc_i);
            j_next = j + CW'(inc_j);
            if (cand_coef != 0) begin
              push            = hold_valid;
              hold_valid_next = 1'b1;
              hold_coef_next  = cand_coef;
              hold_exp_next   = cand_exp;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_addr_first  = i_next[AW-1:0];
  assign rd_addr_second = j_next[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= MS_IDLE;
      i            <= '0;
      j            <= '0;
      hold_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state      <= state_next;
      i          <= i_next;
      j          <= j_next;
      hold_valid <= hold_valid_next;
      if (push) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold_coef <= hold_coef_next;
    hold_exp  <= hold_exp_next;
    if (push) begin
      result <= push_item;
    end
    if (state == MS_IDLE && ctl.start) begin
      subtract <= ctl.subtract;
      overflow <= ctl.overflow;
    end
  end

endmodule

`default_nettype wire

// ----- design/spa_checker.sv -----
// spa_checker: port-level checks on the sparse polynomial add/sub top level
// bound to sparse_polynomial_add_sub; uses spa_pkg
`default_nettype none

module spa_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             item_valid,
  input wire logic             item_stall,
  input wire spa_pkg::item_t   item,
  input wire logic             result_valid,
  input wire logic             result_stall,
  input wire spa_pkg::result_t result
);
  import spa_pkg::*;

  // held result transaction stays put
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // empty result is a zero transaction marked last
  a_zero_item: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.zero_polynomial |->
      result.last && result.result_coefficient == 0 && result.result_exponent == 0)
    else $error("bad empty-result transaction");

  // merged terms that cancel never show up
  a_no_zero_term: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.zero_polynomial |-> result.result_coefficient != 0)
    else $error("zero coefficient term emitted");

  // a compute transaction holds off the next input
  a_compute_stalls: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && (item.kind == KIND_ADD || item.kind == KIND_SUB)
      |=> item_stall)
    else $error("input taken right after compute");

endmodule

bind sparse_polynomial_add_sub spa_checker u_spa_checker (.*);

`default_nettype wire
